// ===== rtl/rsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants shared by the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int OW    = 24;  // ray origin
  localparam int DW    = 18;  // ray direction
  localparam int CW    = 24;  // sphere center
  localparam int RADW  = 23;  // sphere radius
  localparam int LW    = 25;  // center minus origin
  localparam int RRW   = 46;  // radius squared
  localparam int LLW   = 52;  // L.L
  localparam int DOTW  = 45;  // L.D
  localparam int PW    = 29;  // projection p
  localparam int PPW   = 58;  // p*p
  localparam int SXW   = 60;  // discriminant, signed working width
  localparam int SW    = 54;  // discriminant fed to the root
  localparam int QW    = SW / 2;
  localparam int TW    = PW + 1;
  localparam int DTW   = DW + TW;
  localparam int HW    = 34;  // hit point working width
  localparam int DISTW = 26;
  localparam int PTW   = 27;

  localparam logic signed [HW-1:0] PT_MAX = HW'(67108863);
  localparam logic signed [HW-1:0] PT_MIN = -HW'(67108864);
  localparam logic signed [TW-1:0] DIST_MAX = TW'(67108863);

  localparam logic [RADW-1:0] RADIUS_RESET = RADW'(65536);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_MISS    = 2'd0;
  localparam kind_t KIND_OUTSIDE = 2'd1;
  localparam kind_t KIND_INSIDE  = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_CENTER_X = 2'd0;
  localparam reg_idx_t REG_CENTER_Y = 2'd1;
  localparam reg_idx_t REG_CENTER_Z = 2'd2;
  localparam reg_idx_t REG_RADIUS   = 2'd3;

  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic [RADW-1:0]    radius;
  } cfg_t;

  typedef struct packed {
    logic [2:0][OW-1:0] org;
    logic [2:0][DW-1:0] dir;
  } ray_t;

  typedef struct packed {
    kind_t          kind;
    logic [SW-1:0]  disc;
    logic [PW-1:0]  proj;
    ray_t           ray;
  } mid_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [DISTW-1:0]    distance;
    logic [2:0][PTW-1:0] pt;
  } result_t;

endpackage

// ===== rtl/rsi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module rsi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rsi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_front
// Front pipeline: dot products, projection and discriminant, hit classification.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rsi_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  rsi_pkg::ray_t     in_ray,
  output logic              out_valid,
  output rsi_pkg::mid_item_t out_item
);
  import rsi_pkg::*;

  logic                   v1, v2, v3, v4, v5;
  ray_t                   ray1, ray2, ray3, ray4;
  logic signed [LW-1:0]   l1 [3];
  logic [RRW-1:0]         rr1, rr2, rr3, rr4;
  logic signed [2*LW-1:0] llp [3];
  logic signed [LW+DW-1:0] ldp [3];
  logic signed [LLW-1:0]  ll3, ll4;
  logic signed [PW-1:0]   p3, p4;
  logic signed [PPW-1:0]  pp4;
  logic signed [DOTW-1:0] dot;
  logic signed [SXW-1:0]  s;
  logic signed [SXW-1:0]  rr_x;
  logic signed [SXW-1:0]  ll_x;
  kind_t                  kind;
  mid_item_t              item5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 1: L = C - O, r*r
  always_ff @(posedge clk) begin
    if (en) begin
      ray1 <= in_ray;
      rr1  <= RRW'(cfg.radius) * RRW'(cfg.radius);
      for (int i = 0; i < 3; i++) begin
        l1[i] <= LW'($signed(cfg.center[i])) - LW'($signed(in_ray.org[i]));
      end
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      ray2 <= ray1;
      rr2  <= rr1;
      for (int i = 0; i < 3; i++) begin
        llp[i] <= l1[i] * l1[i];
        ldp[i] <= l1[i] * $signed(ray1.dir[i]);
      end
    end
  end

  // stage 3: sums, projection
  assign dot = DOTW'(ldp[0]) + DOTW'(ldp[1]) + DOTW'(ldp[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      ray3 <= ray2;
      rr3  <= rr2;
      ll3  <= LLW'(llp[0]) + LLW'(llp[1]) + LLW'(llp[2]);
      p3   <= dot[DOTW-1:16];
    end
  end

  // stage 4: p*p
  always_ff @(posedge clk) begin
    if (en) begin
      ray4 <= ray3;
      rr4  <= rr3;
      ll4  <= ll3;
      p4   <= p3;
      pp4  <= p3 * p3;
    end
  end

  // stage 5: discriminant, classification
  assign rr_x = $signed({{(SXW-RRW){1'b0}}, rr4});
  assign ll_x = SXW'(ll4);
  assign s    = rr_x - ll_x + SXW'(pp4);

  always_comb begin
    if (rr_x <= ll_x) begin
      if (p4 <= 0 || s <= 0) begin
        kind = KIND_MISS;
      end else begin
        kind = KIND_OUTSIDE;
      end
    end else begin
      kind = KIND_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item5.kind <= kind;
      item5.disc <= (s < 0) ? '0 : s[SW-1:0];
      item5.proj <= p4;
      item5.ray  <= ray4;
    end
  end

  assign out_valid = v5;
  assign out_item  = item5;

endmodule

// ===== rtl/rsi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_back
// Back pipeline: square root one bit per stage, distance and hit point.
// ----------------------------------------------------------------------------
module rsi_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rsi_pkg::mid_item_t in_item,
  output logic               out_valid,
  output rsi_pkg::result_t   out_res
);
  import rsi_pkg::*;

  localparam int RW = QW + 4;

  logic          vld     [QW+1];
  mid_item_t     pl      [QW+1];
  logic [RW-1:0] sq_rem  [QW+1];
  logic [QW-1:0] sq_root [QW+1];
  logic [SW-1:0] sq_rad  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl[0]      <= in_item;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_rad[0]  <= in_item.disc;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          take;

    assign cur   = {sq_rem[k][RW-3:0], sq_rad[k][SW-1:SW-2]};
    assign trial = {2'b00, sq_root[k], 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl[k+1]      <= pl[k];
        sq_rem[k+1]  <= take ? cur - trial : cur;
        sq_root[k+1] <= {sq_root[k][QW-2:0], take};
        sq_rad[k+1]  <= {sq_rad[k][SW-3:0], 2'b00};
      end
    end
  end

  // distance
  logic                  vt, vm;
  kind_t                 kt, km;
  logic signed [TW-1:0]  t_next, tt, tm;
  ray_t                  rayt;
  logic [2:0][OW-1:0]    orgm;
  logic signed [DTW-1:0] dtm [3];
  logic signed [TW-1:0]  q_ext;

  assign q_ext  = $signed({{(TW-QW){1'b0}}, sq_root[QW]});
  assign t_next = (pl[QW].kind == KIND_INSIDE) ? TW'($signed(pl[QW].proj)) + q_ext
                                               : TW'($signed(pl[QW].proj)) - q_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
      vm <= 1'b0;
    end else if (en) begin
      vt <= vld[QW];
      vm <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kt   <= pl[QW].kind;
      tt   <= t_next;
      rayt <= pl[QW].ray;
      km   <= kt;
      tm   <= tt;
      orgm <= rayt.org;
      for (int i = 0; i < 3; i++) begin
        dtm[i] <= $signed(rayt.dir[i]) * tt;
      end
    end
  end

  // hit point and saturation
  logic signed [HW-1:0] h [3];

  always_comb begin
    out_res.kind = km;
    if (tm < 0) begin
      out_res.distance = '0;
    end else if (tm > DIST_MAX) begin
      out_res.distance = DIST_MAX[DISTW-1:0];
    end else begin
      out_res.distance = tm[DISTW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      h[i] = HW'($signed(orgm[i])) + HW'($signed(dtm[i][DTW-1:16]));
      if (h[i] > PT_MAX) begin
        out_res.pt[i] = PT_MAX[PTW-1:0];
      end else if (h[i] < PT_MIN) begin
        out_res.pt[i] = PT_MIN[PTW-1:0];
      end else begin
        out_res.pt[i] = h[i][PTW-1:0];
      end
    end
    if (km == KIND_MISS) begin
      out_res = '0;
    end
  end

  assign out_valid = vm;

endmodule

// ===== rtl/ray_sphere_intersect_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// Ray against configured sphere, Q8.16 positions and Q2.16 direction, queue interfaces on both sides.
// ----------------------------------------------------------------------------
// One ray is taken per clock while the mid queue is not full, and one result
// leaves per clock when pop is held. With no stalls a ray passes five front
// stages (the first at the accepting edge), one mid queue write, one load stage,
// one stage per square root bit (27), two stages for distance and hit point, and
// the output queue write. The square root sets most of that path. A full output
// queue stalls the back pipeline and a full mid queue stalls the front.
// Center and radius must only be written while no ray is in flight.
module ray_sphere_intersect_top #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                push,
  output logic                full,
  input  logic signed [23:0]  ray_origin_x,
  input  logic signed [23:0]  ray_origin_y,
  input  logic signed [23:0]  ray_origin_z,
  input  logic signed [17:0]  ray_dir_x,
  input  logic signed [17:0]  ray_dir_y,
  input  logic signed [17:0]  ray_dir_z,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          hit_kind,
  output logic [25:0]         hit_distance,
  output logic signed [26:0]  hit_x,
  output logic signed [26:0]  hit_y,
  output logic signed [26:0]  hit_z
);
  import rsi_pkg::*;

  cfg_t      cfg;
  ray_t      ray;
  logic      front_en, back_en;
  logic      mid_push, mid_full, mid_empty, mid_pop;
  mid_item_t mid_wdata, mid_rdata;
  logic      out_push, out_full;
  result_t   out_wdata, out_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= '0;
      cfg.radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: cfg.center[0] <= cfg_data;
        REG_CENTER_Y: cfg.center[1] <= cfg_data;
        REG_CENTER_Z: cfg.center[2] <= cfg_data;
        REG_RADIUS:   cfg.radius    <= cfg_data[RADW-1:0];
        default: ;
      endcase
    end
  end

  assign ray.org[0] = ray_origin_x;
  assign ray.org[1] = ray_origin_y;
  assign ray.org[2] = ray_origin_z;
  assign ray.dir[0] = ray_dir_x;
  assign ray.dir[1] = ray_dir_y;
  assign ray.dir[2] = ray_dir_z;

  assign front_en = !mid_full;
  assign full     = mid_full;

  rsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (front_en),
    .cfg      (cfg),
    .in_valid (push && !full),
    .in_ray   (ray),
    .out_valid(mid_push),
    .out_item (mid_wdata)
  );

  rsi_fifo #(.W($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push && front_en),
    .wdata(mid_wdata),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .full (mid_full),
    .empty(mid_empty)
  );

  assign back_en = !out_full;
  assign mid_pop = back_en && !mid_empty;

  rsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (back_en),
    .in_valid (!mid_empty),
    .in_item  (mid_rdata),
    .out_valid(out_push),
    .out_res  (out_wdata)
  );

  rsi_fifo #(.W($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push && back_en),
    .wdata(out_wdata),
    .pop  (pop),
    .rdata(out_rdata),
    .full (out_full),
    .empty(empty)
  );

  assign hit_kind     = out_rdata.kind;
  assign hit_distance = out_rdata.distance;
  assign hit_x        = $signed(out_rdata.pt[0]);
  assign hit_y        = $signed(out_rdata.pt[1]);
  assign hit_z        = $signed(out_rdata.pt[2]);

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_full |=> !(mid_push && front_en && mid_full && !$past(mid_pop)))
    else $error("mid queue overflow");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (mid_push && mid_full) |=> mid_push)
    else $error("front dropped a transaction while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && hit_kind == KIND_MISS) |->
      (hit_distance == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0))
    else $error("miss result carries nonzero fields");

endmodule

// ===== test/ray_sphere_intersect_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_checker
// Watches the config port and both queue sides of the ray / sphere block,
// predicts every result from the accepted rays and compares it field by field.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               push,
  input  logic               full,
  input  logic signed [23:0] ray_origin_x,
  input  logic signed [23:0] ray_origin_y,
  input  logic signed [23:0] ray_origin_z,
  input  logic signed [17:0] ray_dir_x,
  input  logic signed [17:0] ray_dir_y,
  input  logic signed [17:0] ray_dir_z,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         hit_kind,
  input  logic [25:0]        hit_distance,
  input  logic signed [26:0] hit_x,
  input  logic signed [26:0] hit_y,
  input  logic signed [26:0] hit_z,
  output int                 errors,
  output int                 in_flight
);
  import rsi_pkg::*;

  longint    sphere_c[3];
  longint    sphere_r;
  result_t   hits_due[$];

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic result_t trace_ray(longint o[3], longint d[3]);
    result_t res;
    longint  l[3];
    longint  ll, dot, rr, p, s, q, t, v;
    ll = 0;
    dot = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      l[i] = sphere_c[i] - o[i];
      ll += l[i] * l[i];
      dot += l[i] * d[i];
    end
    rr = sphere_r * sphere_r;
    p = dot >>> 16;
    s = rr - ll + p * p;
    if (rr <= ll) begin
      if (p <= 0 || s <= 0) return res;
      q = longint'(root64(s));
      t = p - q;
      res.kind = KIND_OUTSIDE;
    end else begin
      q = longint'(root64(s > 0 ? s : 0));
      t = p + q;
      res.kind = KIND_INSIDE;
    end
    res.distance = DISTW'(clip(t, 0, 67108863));
    for (int i = 0; i < 3; i++) begin
      v = sphere_c[i] + ((d[i] * t) >>> 16) - l[i];
      res.pt[i] = PTW'(clip(v, -67108864, 67108863));
    end
    return res;
  endfunction

  assign in_flight = hits_due.size();

  initial begin
    errors = 0;
    sphere_c = '{0, 0, 0};
    sphere_r = 65536;
  end

  always @(posedge clk) begin
    longint  o[3];
    longint  d[3];
    result_t want;
    if (rst) begin
      sphere_c = '{0, 0, 0};
      sphere_r = 65536;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X: sphere_c[0] = longint'($signed(cfg_data));
          REG_CENTER_Y: sphere_c[1] = longint'($signed(cfg_data));
          REG_CENTER_Z: sphere_c[2] = longint'($signed(cfg_data));
          REG_RADIUS:   sphere_r = longint'(cfg_data[22:0]);
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (hits_due.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = hits_due.pop_front();
          if (hit_kind !== want.kind) begin
            $error("hit_kind expected %0d actual %0d", want.kind, hit_kind);
            errors++;
          end
          if (hit_distance !== want.distance) begin
            $error("hit_distance expected %0d actual %0d", want.distance, hit_distance);
            errors++;
          end
          if (hit_x !== want.pt[0]) begin
            $error("hit_x expected %0d actual %0d", $signed(want.pt[0]), hit_x);
            errors++;
          end
          if (hit_y !== want.pt[1]) begin
            $error("hit_y expected %0d actual %0d", $signed(want.pt[1]), hit_y);
            errors++;
          end
          if (hit_z !== want.pt[2]) begin
            $error("hit_z expected %0d actual %0d", $signed(want.pt[2]), hit_z);
            errors++;
          end
        end
      end
      if (push && !full) begin
        o = '{longint'(ray_origin_x), longint'(ray_origin_y), longint'(ray_origin_z)};
        d = '{longint'(ray_dir_x), longint'(ray_dir_y), longint'(ray_dir_z)};
        hits_due.push_back(trace_ray(o, d));
      end
    end
  end

endmodule

// ===== test/ray_sphere_intersect_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top_test
// Drives rays into the intersection block under several sphere settings,
// directed corner rays first and then mostly aimed random rays, with random
// gaps and stalls on both sides; the checker scores every result.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top_test;
  import rsi_pkg::*;

  localparam int  RANDOM_PER_PHASE = 300;
  localparam int  DRAIN_CYCLES = 45;
  localparam longint CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [23:0] ray_origin_x = '0;
  logic signed [23:0] ray_origin_y = '0;
  logic signed [23:0] ray_origin_z = '0;
  logic signed [17:0] ray_dir_x = '0;
  logic signed [17:0] ray_dir_y = '0;
  logic signed [17:0] ray_dir_z = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         hit_kind;
  logic [25:0]        hit_distance;
  logic signed [26:0] hit_x;
  logic signed [26:0] hit_y;
  logic signed [26:0] hit_z;
  int                 errors;
  int                 in_flight;
  longint             cycles = 0;
  longint             cur_c[3] = '{0, 0, 0};
  longint             cur_r = 65536;
  bit                 send_burst = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_sphere_intersect_top dut (.*);

  ray_sphere_intersect_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, bursts, and one long hold-off
  initial begin
    int n;
    int w;
    bit burst;
    n = 0;
    burst = 0;
    @(negedge rst);
    forever begin
      if (n % 120 == 0) burst = ($urandom_range(0, 2) == 0);
      w = burst ? 0 : $urandom_range(0, 7);
      if (n == 400) w = 500;
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      n++;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic send_ray(longint o[3], longint d[3]);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    ray_origin_x <= 24'(o[0]);
    ray_origin_y <= 24'(o[1]);
    ray_origin_z <= 24'(o[2]);
    ray_dir_x <= 18'(d[0]);
    ray_dir_y <= 18'(d[1]);
    ray_dir_z <= 18'(d[2]);
    do @(posedge clk); while (full);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_sphere(longint cx, longint cy, longint cz, longint r);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_data <= cx[23:0];
    @(posedge clk);
    cfg_index <= REG_CENTER_Y;
    cfg_data <= cy[23:0];
    @(posedge clk);
    cfg_index <= REG_CENTER_Z;
    cfg_data <= cz[23:0];
    @(posedge clk);
    cfg_index <= REG_RADIUS;
    cfg_data <= {1'b0, r[22:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_c = '{cx, cy, cz};
    cur_r = r;
  endtask

  task automatic random_ray();
    longint o[3];
    longint d[3];
    longint span, m, a;
    int mode;
    mode = $urandom_range(0, 9);
    span = (mode < 5) ? cur_r : 4 * cur_r + 65536;
    for (int i = 0; i < 3; i++) begin
      if (mode < 2)
        o[i] = longint'($urandom_range(0, 16777215)) - 8388608;
      else
        o[i] = clamp(cur_c[i] + longint'($urandom_range(0, 2 * span)) - span,
                     -8388608, 8388607);
    end
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a = cur_c[i] - o[i];
      if (a < 0) a = -a;
      if (a > m) m = a;
    end
    for (int i = 0; i < 3; i++) begin
      if (mode < 7 && m != 0)
        d[i] = clamp((cur_c[i] - o[i]) * 65536 / m
                     + longint'($urandom_range(0, 8192)) - 4096, -65536, 65536);
      else
        d[i] = longint'($urandom_range(0, 131072)) - 65536;
    end
    send_ray(o, d);
  endtask

  initial begin
    longint u;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unit sphere at origin after reset
    u = 65536;
    send_ray('{-3 * u, 0, 0}, '{u, 0, 0});            // hit from outside
    send_ray('{-3 * u, 0, 0}, '{-u, 0, 0});           // pointing away
    send_ray('{-3 * u, u, 0}, '{u, 0, 0});            // tangent
    send_ray('{0, 0, 0}, '{0, u, 0});                 // inside, far root
    send_ray('{0, 0, u / 2}, '{0, 0, -u});            // inside off center
    send_ray('{-3 * u, 0, 0}, '{u / 4, 0, 0});        // short direction
    send_ray('{0, 0, 0}, '{0, 0, 0});                 // zero direction inside
    send_ray('{-u, 0, 0}, '{u, 0, 0});                // origin on surface
    send_ray('{-8388608, -8388608, -8388608}, '{u, u, u});
    send_ray('{8388607, 8388607, 8388607}, '{-u, -u, -u});
    send_ray('{8388607, -8388608, 0}, '{-u, u, 0});
    send_ray('{0, 3 * u, 0}, '{0, -u, 0});
    send_ray('{0, 0, -5 * u}, '{1, -1, u});

    // widest sphere, saturating results
    load_sphere(0, 0, 0, 8388607);
    send_ray('{0, 0, 0}, '{u, 0, 0});
    send_ray('{-8388608, -8388608, -8388608}, '{-u, -u, -u});
    send_ray('{8388607, 8388607, 8388607}, '{u, u, u});
    send_ray('{8388607, 0, 0}, '{u, 0, 0});
    load_sphere(8388607, 8388607, 8388607, 8388607);
    send_ray('{8388607, 8388607, 8388607}, '{u, u, u});
    send_ray('{-8388608, -8388608, -8388608}, '{u / 2, u / 2, u / 2});
    load_sphere(-8388608, -8388608, -8388608, 0);
    send_ray('{-8388608, -8388608, -8388608}, '{u, 0, 0});
    send_ray('{8388607, 8388607, 8388607}, '{-u, -u, -u});

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_sphere(0, 0, 0, 65536);
        1: load_sphere(3 * u, -2 * u, u, 2 * u);
        2: load_sphere(8388607, -8388608, 8388607, 8388607);
        default: load_sphere(longint'($urandom_range(0, 16777215)) - 8388608,
                             longint'($urandom_range(0, 16777215)) - 8388608,
                             longint'($urandom_range(0, 16777215)) - 8388608,
                             longint'($urandom_range(0, 4194304)));
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (k % 60 == 0) send_burst = ($urandom_range(0, 2) == 0);
        random_ray();
      end
      send_burst = 0;
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
